### rtl/sprt_pkg.sv
// Shared types and codes for the sync period and relative time block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sprt_pkg;

	localparam int unsigned DataW  = 32;
	localparam int unsigned TimeW  = 64;
	localparam int unsigned CountW = 16;
	localparam int unsigned AddrW  = 4;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_RESET = 2'd1;
	localparam logic [1:0] OP_CALC  = 2'd2;

	localparam logic [1:0] REG_MIN_HOST = 2'd0;
	localparam logic [1:0] REG_MAX_HOST = 2'd1;
	localparam logic [1:0] REG_NET_CYC  = 2'd2;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_ERROR   = 2'd1,
		ST_POLLING = 2'd2
	} status_t;

	typedef struct packed {
		logic [DataW-1:0] min_host;
		logic [DataW-1:0] max_host;
		logic [DataW-1:0] net_cycle;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [DataW-1:0] dividend;
		logic [DataW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DataW-1:0] quotient;
		logic [DataW-1:0] remainder;
	} div_rsp_t;

endpackage

### rtl/sprt_regs.sv
// APB register file for the host cycle limits and the network cycle.
// Depends on sprt_pkg.
`timescale 1ns / 1ps

module sprt_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [sprt_pkg::AddrW-1:0] paddr,
	input  logic [sprt_pkg::DataW-1:0] pwdata,
	output logic [sprt_pkg::DataW-1:0] prdata,
	output logic                      pready,
	output sprt_pkg::cfg_t            cfg
);
	import sprt_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (paddr[AddrW-1:2])
				REG_MIN_HOST: cfg_q.min_host  <= pwdata;
				REG_MAX_HOST: cfg_q.max_host  <= pwdata;
				REG_NET_CYC:  cfg_q.net_cycle <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[AddrW-1:2])
			REG_MIN_HOST: prdata = cfg_q.min_host;
			REG_MAX_HOST: prdata = cfg_q.max_host;
			REG_NET_CYC:  prdata = cfg_q.net_cycle;
			default:      prdata = '0;
		endcase
	end

endmodule

### rtl/sprt_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on sprt_pkg.
`timescale 1ns / 1ps

module sprt_div (
	input  logic                clk,
	input  logic                arst_n,
	input  sprt_pkg::div_req_t  req,
	output sprt_pkg::div_rsp_t  rsp
);
	import sprt_pkg::*;

	localparam int unsigned CntW = $clog2(DataW);

	logic [DataW-1:0] rem_q;
	logic [DataW-1:0] quo_q;
	logic [DataW-1:0] dsr_q;
	logic [CntW-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DataW:0]   rem_sh;
	logic [DataW:0]   diff;

	assign rem_sh = {rem_q, quo_q[DataW-1]};
	assign diff   = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(DataW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			// keep the trial difference when it did not go negative
			if (!diff[DataW]) begin
				rem_q <= diff[DataW-1:0];
				quo_q <= {quo_q[DataW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DataW-1:0];
				quo_q <= {quo_q[DataW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

### rtl/sync_period_and_relative_time.sv
// Sync period and relative time: tick, reset and calculate words, one result word each.
// Tick, reset, unused ops and calculate words that need no division: result valid in the cycle after acceptance.
// Calculate with division: result valid once the 32-step divider loop is done and S_DIV passes to S_DONE.
// One word in flight; the next is accepted the cycle after the result is taken.
// Asynchronous active-low reset clears time, mode, step, count and registers.
// Depends on sprt_pkg, sprt_regs and sprt_div.
`timescale 1ns / 1ps

module sync_period_and_relative_time (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  op,
	input  logic [sprt_pkg::TimeW-1:0]  given_time,
	input  logic                        time_valid,
	input  logic                        node_operational,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [sprt_pkg::TimeW-1:0]  relative_time,
	output logic                        published,
	output logic [sprt_pkg::CountW-1:0] sync_cycles,
	output logic [sprt_pkg::DataW-1:0]  sync_period,
	output logic [1:0]                  status,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sprt_pkg::AddrW-1:0]  paddr,
	input  logic [sprt_pkg::DataW-1:0]  pwdata,
	output logic [sprt_pkg::DataW-1:0]  prdata,
	output logic                        pready
);
	import sprt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t            state_q;
	cfg_t              cfg;
	div_req_t          dreq;
	div_rsp_t          drsp;
	logic              mode_q;
	logic [TimeW-1:0]  time_q;
	logic [DataW-1:0]  step_q;
	logic [CountW-1:0] cycles_q;
	logic              pub_q;
	status_t           status_q;
	logic              accept;
	logic              need_div;
	logic [TimeW-1:0]  tick_base;
	logic              rem_nz;
	logic [DataW:0]    product;
	logic [DataW:0]    count;
	logic              calc_err;

	sprt_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	sprt_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (dreq),
		.rsp   (drsp)
	);

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid & in_ready;
	assign need_div = (op == OP_CALC) && (cfg.net_cycle != '0)
		&& ((cfg.min_host != '0) || (cfg.max_host != '0));

	assign dreq.start    = accept & need_div;
	assign dreq.dividend = cfg.min_host;
	assign dreq.divisor  = cfg.net_cycle;

	// waiting and operational with a valid time: load the master's time first
	assign tick_base = (!mode_q && node_operational && time_valid) ? given_time : time_q;

	// rounded-up count times cycle equals min - rem + cycle when rem is nonzero
	assign rem_nz   = (drsp.remainder != '0);
	assign product  = {1'b0, cfg.min_host} - {1'b0, drsp.remainder}
		+ (rem_nz ? {1'b0, cfg.net_cycle} : '0);
	assign count    = {1'b0, drsp.quotient} + {{DataW{1'b0}}, rem_nz};
	assign calc_err = product[DataW] || (product[DataW-1:0] > cfg.max_host)
		|| (count > (DataW+1)'({CountW{1'b1}}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			mode_q   <= 1'b0;
			time_q   <= '0;
			step_q   <= '0;
			cycles_q <= '0;
			pub_q    <= 1'b0;
			status_q <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						pub_q    <= 1'b0;
						status_q <= ST_OK;
						state_q  <= S_DONE;
						case (op)
							OP_TICK: begin
								time_q <= tick_base + {{(TimeW-DataW){1'b0}}, step_q};
								if (mode_q || node_operational) begin
									pub_q  <= 1'b1;
									mode_q <= 1'b1;
								end
							end
							OP_RESET: begin
								time_q <= '0;
								mode_q <= 1'b0;
							end
							OP_CALC: begin
								if (need_div) begin
									state_q <= S_DIV;
								end else begin
									cycles_q <= '0;
									status_q <= (cfg.net_cycle == '0) ? ST_ERROR : ST_POLLING;
								end
							end
							default: ;
						endcase
					end
				end
				S_DIV: begin
					if (drsp.done) begin
						state_q <= S_DONE;
						if (calc_err) begin
							cycles_q <= '0;
							status_q <= ST_ERROR;
						end else begin
							cycles_q <= count[CountW-1:0];
							step_q   <= product[DataW-1:0];
						end
					end
				end
				S_DONE: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = (state_q == S_DONE);
	assign relative_time = time_q;
	assign published     = pub_q;
	assign sync_cycles   = cycles_q;
	assign sync_period   = step_q;
	assign status        = status_q;

endmodule

### rtl/sprt_checker.sv
// Port-level checks for sync_period_and_relative_time, bound to the top level.
// Depends on sprt_pkg and sync_period_and_relative_time.
`timescale 1ns / 1ps

module sprt_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [sprt_pkg::TimeW-1:0]  relative_time,
	input logic                        published,
	input logic [sprt_pkg::CountW-1:0] sync_cycles,
	input logic [1:0]                  status
);
	import sprt_pkg::*;

	// a stalled result word stays valid and keeps its relative time
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(relative_time))
		else $error("result word changed while stalled");

	// one word in flight: no acceptance while a result waits
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while result pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready straight after acceptance");

	a_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_ERROR || status == ST_POLLING) |-> sync_cycles == '0)
		else $error("nonzero sync count with error or polling status");

	a_pub_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && published |-> status == ST_OK)
		else $error("published word with non-ok status");

endmodule

bind sync_period_and_relative_time sprt_checker u_sprt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.relative_time(relative_time),
	.published    (published),
	.sync_cycles  (sync_cycles),
	.status       (status)
);

### tb/sprt_time_checker.sv
// Checker for the sync period and relative time block: predicts each result word
// from the accepted input words and register writes, and compares field by field.
// Depends on sprt_pkg.
`timescale 1ns / 1ps

module sprt_time_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [1:0]                  op,
	input  logic [sprt_pkg::TimeW-1:0]  given_time,
	input  logic                        time_valid,
	input  logic                        node_operational,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [sprt_pkg::TimeW-1:0]  relative_time,
	input  logic                        published,
	input  logic [sprt_pkg::CountW-1:0] sync_cycles,
	input  logic [sprt_pkg::DataW-1:0]  sync_period,
	input  logic [1:0]                  status,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sprt_pkg::AddrW-1:0]  paddr,
	input  logic [sprt_pkg::DataW-1:0]  pwdata,
	input  logic                        pready,
	output int                          mismatches,
	output int                          outstanding,
	output int                          compared
);
	import sprt_pkg::*;

	typedef struct {
		logic [TimeW-1:0]  rel_time;
		logic              pub;
		logic [CountW-1:0] cycles;
		logic [DataW-1:0]  period;
		status_t           stat;
	} time_word_t;

	cfg_t              regs_q;
	logic              running;
	logic [TimeW-1:0]  clk_time;
	logic [DataW-1:0]  step;
	logic [CountW-1:0] per_sync;
	time_word_t        awaited_q[$];
	int                fail_tally;
	int                seen;

	// Smallest whole number of network cycles covering the minimum host cycle, or an error or polling status.
	function automatic status_t derive_period();
		logic [63:0] cnt;
		logic [63:0] prod;
		if (regs_q.net_cycle == '0) begin
			per_sync = '0;
			return ST_ERROR;
		end
		if (regs_q.min_host == '0 && regs_q.max_host == '0) begin
			per_sync = '0;
			return ST_POLLING;
		end
		cnt = {32'd0, regs_q.min_host / regs_q.net_cycle};
		if (regs_q.min_host % regs_q.net_cycle != '0)
			cnt = cnt + 64'd1;
		prod = cnt * {32'd0, regs_q.net_cycle};
		if (prod > 64'h0000_0000_FFFF_FFFF || prod > {32'd0, regs_q.max_host} ||
				cnt > 64'h0000_0000_0000_FFFF) begin
			per_sync = '0;
			return ST_ERROR;
		end
		per_sync = cnt[CountW-1:0];
		step = prod[DataW-1:0];
		return ST_OK;
	endfunction

	function automatic time_word_t next_word(logic [1:0] code, logic [TimeW-1:0] t,
			logic tv, logic on);
		time_word_t r;
		r.pub = 1'b0;
		r.stat = ST_OK;
		case (code)
			OP_TICK: begin
				// first operational tick while waiting takes the master's time if valid
				if (!running && on) begin
					if (tv)
						clk_time = t;
					running = 1'b1;
					r.pub = 1'b1;
				end else if (running) begin
					r.pub = 1'b1;
				end
				clk_time = clk_time + {32'd0, step};
			end
			OP_RESET: begin
				clk_time = '0;
				running = 1'b0;
			end
			OP_CALC: r.stat = derive_period();
			default: ;
		endcase
		r.rel_time = clk_time;
		r.cycles = per_sync;
		r.period = step;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		time_word_t want;
		if (!arst_n) begin
			regs_q = '0;
			running = 1'b0;
			clk_time = '0;
			step = '0;
			per_sync = '0;
			awaited_q.delete();
			fail_tally = 0;
			seen = 0;
			mismatches <= 0;
			outstanding <= 0;
			compared <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_q.size() == 0) begin
					fail_tally++;
					if (fail_tally <= 10)
						$display("%0t: result word with nothing expected: time=%h pub=%b",
							$time, relative_time, published);
				end else begin
					want = awaited_q.pop_front();
					seen++;
					if (relative_time !== want.rel_time || published !== want.pub ||
							sync_cycles !== want.cycles || sync_period !== want.period ||
							status !== want.stat) begin
						fail_tally++;
						if (fail_tally <= 10)
							$display({"%0t: mismatch: expected time=%h pub=%b cycles=%0d ",
								"period=%0d status=%0d, got time=%h pub=%b cycles=%0d ",
								"period=%0d status=%0d"}, $time,
								want.rel_time, want.pub, want.cycles, want.period, want.stat,
								relative_time, published, sync_cycles, sync_period, status);
					end
				end
			end
			if (in_valid && in_ready)
				awaited_q.push_back(next_word(op, given_time, time_valid, node_operational));
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_MIN_HOST: regs_q.min_host = pwdata;
					REG_MAX_HOST: regs_q.max_host = pwdata;
					REG_NET_CYC:  regs_q.net_cycle = pwdata;
					default: ;
				endcase
			end
			mismatches <= fail_tally;
			outstanding <= awaited_q.size();
			compared <= seen;
		end
	end

endmodule

### tb/sync_period_and_relative_time_tb.sv
// Top of the sync period and relative time testbench: clock, reset, stimulus and verdict.
// Depends on sprt_pkg, the block itself and sprt_time_checker.
`timescale 1ns / 1ps

module sync_period_and_relative_time_tb;
	import sprt_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [1:0]        op;
	logic [TimeW-1:0]  given_time;
	logic              time_valid;
	logic              node_operational;
	logic              out_valid;
	logic              out_ready;
	logic [TimeW-1:0]  relative_time;
	logic              published;
	logic [CountW-1:0] sync_cycles;
	logic [DataW-1:0]  sync_period;
	logic [1:0]        status;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [AddrW-1:0]  paddr;
	logic [DataW-1:0]  pwdata;
	logic [DataW-1:0]  prdata;
	logic              pready;

	int mismatches;
	int outstanding;
	int compared;
	int words_sent;
	int settings_used;
	int rx_hold_cycles;
	bit tx_eager;
	bit rx_eager;

	sync_period_and_relative_time dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .given_time(given_time), .time_valid(time_valid),
		.node_operational(node_operational),
		.out_valid(out_valid), .out_ready(out_ready),
		.relative_time(relative_time), .published(published),
		.sync_cycles(sync_cycles), .sync_period(sync_period), .status(status),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	sprt_time_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .given_time(given_time), .time_valid(time_valid),
		.node_operational(node_operational),
		.out_valid(out_valid), .out_ready(out_ready),
		.relative_time(relative_time), .published(published),
		.sync_cycles(sync_cycles), .sync_period(sync_period), .status(status),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.mismatches(mismatches), .outstanding(outstanding), .compared(compared)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic int draw_wait(bit eager);
		return eager ? 0 : int'($urandom_range(0, 17));
	endfunction

	// Keep valid high straight into the next word when there is no gap.
	task automatic send_word(logic [1:0] code, logic [TimeW-1:0] t, logic tv, logic on);
		int gap;
		gap = draw_wait(tx_eager);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		given_time <= t;
		time_valid <= tv;
		node_operational <= on;
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	// Drop valid and wait for every outstanding result word.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [DataW-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic load_cfg(logic [DataW-1:0] lo, logic [DataW-1:0] hi, logic [DataW-1:0] net);
		settle();
		write_reg(REG_MIN_HOST, lo);
		write_reg(REG_MAX_HOST, hi);
		write_reg(REG_NET_CYC, net);
		settings_used++;
	endtask

	task automatic pick_cfg();
		logic [DataW-1:0] lo;
		logic [DataW-1:0] hi;
		logic [DataW-1:0] net;
		int unsigned cnt;
		case ($urandom_range(0, 6))
			0: begin
				lo = $urandom;
				hi = $urandom;
				net = $urandom;
			end
			1: begin
				lo = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
				hi = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
				net = ($urandom_range(0, 2) == 0) ? 32'd0 :
					($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1);
			end
			2: begin
				lo = '0;
				hi = '0;
				net = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
			end
			3: begin
				// hover around the 16-bit count limit
				net = $urandom_range(1, 4);
				lo = net * $urandom_range(65500, 65540);
				hi = 32'hFFFF_FFFF;
			end
			default: begin
				net = $urandom_range(1, 200000);
				cnt = $urandom_range(1, 2000);
				lo = net * (cnt - 1) + $urandom_range(1, net);
				hi = lo + $urandom_range(0, 3 * net);
				if ($urandom_range(0, 7) == 0)
					lo = '0;
			end
		endcase
		load_cfg(lo, hi, net);
	endtask

	task automatic send_random();
		int pick;
		logic [1:0] code;
		logic [TimeW-1:0] t;
		pick = $urandom_range(0, 99);
		code = (pick < 70) ? OP_TICK : (pick < 80) ? OP_RESET : (pick < 94) ? OP_CALC : OP_SPARE;
		case ($urandom_range(0, 9))
			0: t = '0;
			1: t = '1;
			2: t = {32'hFFFF_FFFF, $urandom};
			default: t = {$urandom, $urandom};
		endcase
		send_word(code, t, 1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0);
	endtask

	// Result side: stall per word, with one long hold-off on request.
	initial begin : drain_side
		int stall;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (rx_hold_cycles) @(posedge clk);
				rx_hold_cycles = 0;
			end
			stall = draw_wait(rx_eager);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : stimulus
		int ph;
		int n;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		op <= OP_TICK;
		given_time <= '0;
		time_valid <= 1'b0;
		node_operational <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		tx_eager = 1'b0;
		rx_eager = 1'b0;
		rx_hold_cycles = 0;
		words_sent = 0;
		settings_used = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers still at reset: zero network cycle
		send_word(OP_CALC, '0, 1'b0, 1'b0);
		send_word(OP_SPARE, '1, 1'b1, 1'b1);
		send_word(OP_TICK, '1, 1'b1, 1'b0);
		load_cfg(32'd0, 32'd0, 32'd100);
		send_word(OP_CALC, '0, 1'b0, 1'b0);
		load_cfg(32'd250, 32'd300, 32'd100);
		send_word(OP_CALC, '0, 1'b0, 1'b0);
		send_word(OP_TICK, 64'h1234, 1'b1, 1'b0);
		send_word(OP_TICK, 64'h5678, 1'b0, 1'b1);
		send_word(OP_TICK, 64'h9ABC, 1'b1, 1'b1);
		send_word(OP_RESET, '1, 1'b1, 1'b1);
		send_word(OP_TICK, 64'hFFFF_FFFF_FFFF_FF00, 1'b1, 1'b1);
		send_word(OP_TICK, '0, 1'b0, 1'b0);
		load_cfg(32'd250, 32'd299, 32'd100);
		send_word(OP_CALC, '0, 1'b0, 1'b0);
		send_word(OP_TICK, '0, 1'b0, 1'b1);
		load_cfg(32'd0, 32'd5, 32'd100);
		send_word(OP_CALC, '0, 1'b0, 1'b0);
		send_word(OP_TICK, '0, 1'b0, 1'b1);
		load_cfg(32'h0001_0000, 32'hFFFF_FFFF, 32'd1);
		send_word(OP_CALC, '0, 1'b0, 1'b0);
		load_cfg(32'h0000_FFFF, 32'hFFFF_FFFF, 32'd1);
		send_word(OP_CALC, '0, 1'b0, 1'b0);
		load_cfg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
		send_word(OP_CALC, '0, 1'b0, 1'b0);
		load_cfg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(OP_CALC, '0, 1'b0, 1'b0);
		send_word(OP_RESET, '0, 1'b0, 1'b0);
		send_word(OP_TICK, '1, 1'b1, 1'b1);
		send_word(OP_TICK, '0, 1'b0, 1'b0);
		send_word(OP_SPARE, '0, 1'b0, 1'b0);

		for (ph = 0; ph < 20; ph++) begin
			tx_eager = ($urandom_range(0, 3) == 0);
			rx_eager = ($urandom_range(0, 3) == 0);
			pick_cfg();
			if (ph == 4) begin
				// hold the result side off while words keep coming
				tx_eager = 1'b1;
				rx_eager = 1'b0;
				rx_hold_cycles = 400;
			end
			send_word(OP_CALC, {$urandom, $urandom}, 1'($urandom_range(0, 1)), 1'b1);
			for (n = 0; n < 31; n++) begin
				if (n == 15 && ph % 5 == 2)
					settle();
				send_random();
			end
		end

		settle();
		repeat (40) @(posedge clk);
		$display("Summary: %0d words sent under %0d register settings, %0d results checked",
			words_sent, settings_used, compared);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
